// ===== rtl/lmc3_pkg.sv =====
// Shared types, constants and the peak test for the 3x3 local maximum counter.
package lmc3_pkg;

  localparam int VALUE_W     = 16;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int SIZE_W      = 11;
  localparam int POS_W       = 10;
  localparam int COUNT_W     = 21;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int LINE_W      = 2 * VALUE_W;

  localparam logic [COUNT_W-1:0]   COUNT_MAX        = {COUNT_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  typedef logic signed [VALUE_W-1:0] value_t;
  // window[row][col]: row 0 is matrix row r-2, col 0 is matrix column c-2
  typedef value_t [2:0][2:0] window_t;

  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // Strict maximum test of window cell (cr, cc) against its in-window neighbors.
  // row_ok / col_ok mark window rows / columns that lie inside the matrix.
  function automatic logic is_peak(window_t w, int cr, int cc,
                                   logic [2:0] row_ok, logic [2:0] col_ok);
    logic peak;
    peak = 1'b1;
    for (int di = 0; di < 3; di++) begin
      for (int dj = 0; dj < 3; dj++) begin
        if (!(di == cr && dj == cc) && di >= cr - 1 && di <= cr + 1 &&
            dj >= cc - 1 && dj <= cc + 1 && row_ok[di] && col_ok[dj] &&
            ($signed(w[cr][cc]) <= $signed(w[di][dj]))) begin
          peak = 1'b0;
        end
      end
    end
    return peak;
  endfunction

endpackage

// ===== rtl/lmc3_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module lmc3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/local_maximum_counter_3x3.sv =====
// Strict 8-neighbor local maximum counter over a raster-ordered matrix.
// Elements arrive one per item on the in_ stream; the matrix size comes from the
// row_count and column_count registers (zero acts as 1, values above 1024 act as
// 1024), and any register write restarts the frame. The block takes one item per
// clock cycle unless input is held off: a registered window stage is followed by
// the peak compare and count stage, and the single result, the frame's total,
// leaves from an output register after the final item passes the window stage.
// The two line buffers share one dual-port RAM whose registered read is issued
// one column ahead, so the line buffer read never stalls input. Input is held off
// only while a finished total waits in the output register and the next frame's
// final item reaches stage 1. The line buffers need no clearing after reset.
module local_maximum_counter_3x3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [lmc3_pkg::VALUE_W-1:0] in_tdata,   // [15:0] pixel_value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmc3_pkg::OUT_DATA_W-1:0]     out_tdata,  // [20:0] maximum_count
  input  logic                                cfg_we,
  input  logic [lmc3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmc3_pkg::SIZE_W-1:0]         cfg_wdata
);

  import lmc3_pkg::*;

  // configuration
  logic [SIZE_W-1:0] row_count_r, column_count_r;
  logic [SIZE_W-1:0] rows_eff, cols_eff;

  // positions of the next item
  logic [POS_W-1:0] row_r, row_nxt, col_r, col_nxt;

  // line buffer RAM and forwarding for a same-address write/read
  logic [LINE_W-1:0] ram_rdata, wr_data, fwd_data_r, line_cur;
  logic              fwd_r;
  value_t            prev_cur, sec_cur;

  // stage 1: window and position flags
  window_t    win_r;
  pos_flags_t flags_r, flags_nxt;
  logic       s1_valid_r;
  logic       s1_final;

  // stage 2: count and output
  logic [COUNT_W-1:0]    count_r, count_sat;
  logic [COUNT_W:0]      count_sum;
  logic [2:0]            peak_n;
  logic [3:0]            peaks;
  logic [2:0]            row_ok, col_ok;
  logic                  s2_go;
  logic                  accept;
  logic                  out_valid_r;
  logic [COUNT_W-1:0]    out_count_r;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (row_count_r > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
    if (column_count_r == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (column_count_r > SIZE_W'(MAX_COLUMNS)) begin
      cols_eff = SIZE_W'(MAX_COLUMNS);
    end else begin
      cols_eff = column_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= SIZE_W'(1);
      column_count_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_final  = flags_r.last_row && flags_r.last_col;
  assign s2_go     = s1_valid_r && (!s1_final || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_go;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    flags_nxt.row_ge1  = row_r >= POS_W'(1);
    flags_nxt.row_ge2  = row_r >= POS_W'(2);
    flags_nxt.col_ge1  = col_r >= POS_W'(1);
    flags_nxt.col_ge2  = col_r >= POS_W'(2);
    flags_nxt.last_row = ({1'b0, row_r} + SIZE_W'(1)) >= rows_eff;
    flags_nxt.last_col = ({1'b0, col_r} + SIZE_W'(1)) >= cols_eff;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (flags_nxt.last_col) begin
        col_nxt = '0;
        row_nxt = flags_nxt.last_row ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // RAM word: low half is row r-1, high half is row r-2 at that column
  assign line_cur = fwd_r ? fwd_data_r : ram_rdata;
  assign prev_cur = line_cur[VALUE_W-1:0];
  assign sec_cur  = line_cur[LINE_W-1:VALUE_W];
  assign wr_data  = {prev_cur, in_tdata};

  // read runs one column ahead so the data is ready when the item arrives
  lmc3_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_COLUMNS)
  ) u_line_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(col_r),
    .wdata(wr_data),
    .raddr(col_nxt),
    .rdata(ram_rdata)
  );

  // single-column frames write and read the same entry at one edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= accept && (col_nxt == col_r);
    end
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      s1_valid_r <= 1'b0;
      flags_r    <= '0;
    end else begin
      if (accept) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= sec_cur;
        win_r[1][2] <= prev_cur;
        win_r[2][2] <= in_tdata;
        flags_r     <= flags_nxt;
        s1_valid_r  <= 1'b1;
      end else if (s2_go) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  assign row_ok = {1'b1, flags_r.row_ge1, flags_r.row_ge2};
  assign col_ok = {1'b1, flags_r.col_ge1, flags_r.col_ge2};

  always_comb begin
    peaks[0] = flags_r.row_ge1 && flags_r.col_ge1 && is_peak(win_r, 1, 1, row_ok, col_ok);
    peaks[1] = flags_r.row_ge1 && flags_r.last_col && is_peak(win_r, 1, 2, row_ok, col_ok);
    peaks[2] = flags_r.last_row && flags_r.col_ge1 && is_peak(win_r, 2, 1, row_ok, col_ok);
    peaks[3] = flags_r.last_row && flags_r.last_col && is_peak(win_r, 2, 2, row_ok, col_ok);
    peak_n    = 3'(peaks[0]) + 3'(peaks[1]) + 3'(peaks[2]) + 3'(peaks[3]);
    count_sum = {1'b0, count_r} + (COUNT_W + 1)'(peak_n);
    count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= '0;
      end else if (s2_go) begin
        count_r <= s1_final ? '0 : count_sat;
      end
      if (s2_go && s1_final) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s2_go && s1_final) begin
      out_count_r <= count_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - COUNT_W){1'b0}}, out_count_r};

  // forwarding only happens in single-column frames
  a_fwd_col0: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (col_r == '0))
    else $error("line forward outside single-column frame");

  // a total appears only after a frame's final element went through stage 2
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_final))
    else $error("result without final element");

  // positions stay inside the configured frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < cols_eff) && ({1'b0, row_r} < rows_eff))
    else $error("position outside frame");

  // input stalls only behind a held stage 1 entry
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_final && out_valid_r && !out_tready))
    else $error("unexpected input stall");

endmodule
